// File: src/texture_container_header_parser_core_defines.svh
// Assertion macros shared by the texture container header parser.
`ifndef TEXTURE_CONTAINER_HEADER_PARSER_CORE_DEFINES_SVH
`define TEXTURE_CONTAINER_HEADER_PARSER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TCHP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TCHP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TCHP_ASSERT_IMPL(lbl, ante, cons)
`define TCHP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: src/tchp_pkg.sv
package tchp_pkg;

    localparam int MAX_LEVELS = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int TDATA_W = 296;

    localparam logic [0:11][7:0] IDENT_V1 = {8'hAB, 8'h4B, 8'h54, 8'h58, 8'h20, 8'h31,
                                             8'h31, 8'hBB, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
    localparam logic [0:11][7:0] IDENT_V2 = {8'hAB, 8'h4B, 8'h54, 8'h58, 8'h20, 8'h32,
                                             8'h30, 8'hBB, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
    localparam logic [31:0] V1_HEADER_LEN = 32'd64;
    localparam logic [31:0] V2_HEADER_LEN = 32'd80;
    localparam logic [33:0] V2_ENTRY_LEN = 34'd24;

    localparam logic [1:0] VER_NONE = 2'd0;
    localparam logic [1:0] VER_ONE = 2'd1;
    localparam logic [1:0] VER_TWO = 2'd2;

    localparam logic [1:0] REG_FILE_LENGTH = 2'd0;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_LEVEL = 2'd1,
        KIND_DONE = 2'd2,
        KIND_UNKNOWN = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        WALK_IDLE = 2'd0,
        WALK_V1 = 2'd1,
        WALK_V2 = 2'd2
    } walk_t;

    typedef struct packed {
        kind_t       kind;
        logic [1:0]  version;
        logic [31:0] format_code;
        logic [31:0] width;
        logic [31:0] height;
        logic [31:0] depth;
        logic [31:0] layers;
        logic [31:0] faces;
        logic [31:0] count_or_index;
        logic [31:0] level_offset;
        logic [31:0] level_length;
        logic        last_of_run;
    } result_t;

    // Up to two requests leave the parser for one byte, first one in r0.
    typedef struct packed {
        logic [1:0] num;
        result_t    r0;
        result_t    r1;
    } push_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
    } qstat_t;

    function automatic result_t new_row(kind_t kind, logic [1:0] ver);
        result_t r;
        r = '0;
        r.kind = kind;
        r.version = ver;
        return r;
    endfunction

endpackage

// File: src/tchp_parser.sv
module tchp_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  logic [7:0]          byte_value,
    input  logic                start_of_file,
    input  logic [31:0]         file_length,
    output tchp_pkg::push_t     push
);

    typedef struct packed {
        logic [31:0]       pos;
        logic [1:0]        ver;
        logic              ok1;
        logic              ok2;
        logic [63:0]       wa;
        logic [7:0][31:0]  hw;
        logic [33:0]       nrp;
        logic [5:0]        lc;
        logic [31:0]       lw;
        logic [31:0]       lh;
        tchp_pkg::walk_t   walk;
        logic              stop;
    } pstate_t;

    localparam pstate_t PARSE_CLEAR = '{pos: '0, ver: tchp_pkg::VER_NONE, ok1: 1'b1,
        ok2: 1'b1, wa: '0, hw: '0, nrp: '0, lc: '0, lw: '0, lh: '0,
        walk: tchp_pkg::WALK_IDLE, stop: 1'b0};

    pstate_t st_reg;
    pstate_t st_next;

    function automatic logic [31:0] halve(logic [31:0] v);
        return (v > 32'd1) ? (v >> 1) : 32'd1;
    endfunction

    always_comb begin
        pstate_t          c;
        pstate_t          n;
        tchp_pkg::result_t ra;
        tchp_pkg::result_t rb;
        tchp_pkg::result_t lvl;
        logic [1:0]       num;
        logic [31:0]      pos;
        logic [31:0]      len;
        logic [34:0]      pos35;
        logic [5:0]       o6;
        logic             emit;
        logic [31:0]      e_off;
        logic [31:0]      e_len;
        logic [32:0]      body;
        logic [31:0]      nword;
        logic [31:0]      lv;
        logic [5:0]       lc_inc;
        logic [31:0]      o32;
        logic             hdr;

        c = start_of_file ? PARSE_CLEAR : st_reg;
        n = c;
        ra = '0;
        rb = '0;
        lvl = '0;
        num = 2'd0;
        pos = c.pos;
        len = file_length;
        pos35 = {3'b0, pos};
        o6 = pos[5:0] - 6'd3;
        emit = 1'b0;
        e_off = '0;
        e_len = '0;
        body = {1'b0, pos} + 33'd1;
        nword = '0;
        lv = '0;
        lc_inc = '0;
        o32 = '0;
        hdr = 1'b0;

        if (pos < len) begin
            n.wa = {byte_value, c.wa[63:8]};
            if (pos < 32'd12) begin
                if (byte_value != tchp_pkg::IDENT_V1[pos[3:0]]) n.ok1 = 1'b0;
                if (byte_value != tchp_pkg::IDENT_V2[pos[3:0]]) n.ok2 = 1'b0;
                if (pos == 32'd11) begin
                    if (n.ok1 && len >= tchp_pkg::V1_HEADER_LEN) n.ver = tchp_pkg::VER_ONE;
                    else if (n.ok2 && len >= tchp_pkg::V2_HEADER_LEN)
                        n.ver = tchp_pkg::VER_TWO;
                    else n.ver = tchp_pkg::VER_NONE;
                end
            end
            // Header words land in fixed slots as their last byte arrives.
            if (pos < 32'd64 && pos[1:0] == 2'b11) begin
                if (n.ver == tchp_pkg::VER_ONE) begin
                    if (o6 == 6'd28) n.hw[0] = n.wa[63:32];
                    else if (o6 inside {[6'd36:6'd60]})
                        n.hw[3'(o6[5:2] - 4'd8)] = n.wa[63:32];
                end else if (n.ver == tchp_pkg::VER_TWO) begin
                    if (o6 == 6'd12) n.hw[0] = n.wa[63:32];
                    else if (o6 inside {[6'd20:6'd40]})
                        n.hw[3'(o6[5:2] - 4'd4)] = n.wa[63:32];
                end
            end

            hdr = (n.ver == tchp_pkg::VER_ONE && pos == 32'd63) ||
                  (n.ver == tchp_pkg::VER_TWO && pos == 32'd79);
            if (hdr) begin
                lv = n.hw[6];
                ra = tchp_pkg::new_row(tchp_pkg::KIND_HEADER, n.ver);
                ra.format_code = n.hw[0];
                ra.width = n.hw[1];
                ra.height = n.hw[2];
                ra.depth = n.hw[3];
                ra.layers = n.hw[4];
                ra.faces = n.hw[5];
                ra.count_or_index = lv;
                num = 2'd1;
                n.lw = n.hw[1];
                n.lh = n.hw[2];
                n.lc = '0;
                n.stop = 1'b0;
                if (lv >= 32'd1 && lv <= 32'(tchp_pkg::MAX_LEVELS)) begin
                    if (n.ver == tchp_pkg::VER_ONE) begin
                        if (n.hw[7] <= len - tchp_pkg::V1_HEADER_LEN) begin
                            n.walk = tchp_pkg::WALK_V1;
                            n.nrp = {2'b0, tchp_pkg::V1_HEADER_LEN} + {2'b0, n.hw[7]};
                        end
                    end else if ({2'b0, tchp_pkg::V2_HEADER_LEN} +
                                 34'(lv[5:0]) * tchp_pkg::V2_ENTRY_LEN <= {2'b0, len}) begin
                        n.walk = tchp_pkg::WALK_V2;
                        n.nrp = {2'b0, tchp_pkg::V2_HEADER_LEN};
                    end
                end
            end else if (c.walk == tchp_pkg::WALK_V1 && !c.stop) begin
                if (pos35 == {1'b0, c.nrp} + 35'd3) begin
                    nword = n.wa[63:32];
                    if (body > {1'b0, len} ||
                        {2'b0, nword} > ({2'b0, len} - {1'b0, body})) begin
                        n.stop = 1'b1;
                    end else begin
                        emit = 1'b1;
                        e_off = body[31:0];
                        e_len = nword;
                        n.nrp = ({1'b0, body} + {2'b0, nword} + 34'd3) & ~34'd3;
                    end
                end
            end else if (c.walk == tchp_pkg::WALK_V2 && !c.stop) begin
                if (pos35 == {1'b0, c.nrp} + 35'd7) begin
                    if (n.wa > {32'b0, len}) n.stop = 1'b1;
                    else n.hw[7] = n.wa[31:0];
                end else if (pos35 == {1'b0, c.nrp} + 35'd15) begin
                    o32 = c.hw[7];
                    if (o32 > len || n.wa > {32'b0, len - o32}) begin
                        n.stop = 1'b1;
                    end else begin
                        emit = 1'b1;
                        e_off = o32;
                        e_len = n.wa[31:0];
                        n.nrp = c.nrp + tchp_pkg::V2_ENTRY_LEN;
                    end
                end
            end

            if (emit) begin
                lvl = tchp_pkg::new_row(tchp_pkg::KIND_LEVEL, n.ver);
                lvl.width = c.lw;
                lvl.height = c.lh;
                lvl.count_or_index = {26'b0, c.lc};
                lvl.level_offset = e_off;
                lvl.level_length = e_len;
                ra = lvl;
                num = 2'd1;
                n.lw = halve(c.lw);
                n.lh = halve(c.lh);
                lc_inc = c.lc + 6'd1;
                n.lc = lc_inc;
                if ({26'b0, lc_inc} >= c.hw[6]) n.stop = 1'b1;
            end

            if (pos == len - 32'd1) begin
                if (n.ver != tchp_pkg::VER_NONE) begin
                    rb = tchp_pkg::new_row(tchp_pkg::KIND_DONE, n.ver);
                    rb.count_or_index = {26'b0, n.lc};
                end else begin
                    rb = tchp_pkg::new_row(tchp_pkg::KIND_UNKNOWN, n.ver);
                end
                rb.last_of_run = 1'b1;
                if (num == 2'd0) begin
                    ra = rb;
                    num = 2'd1;
                end else begin
                    num = 2'd2;
                end
            end else if (num == 2'd1) begin
                ra.last_of_run = 1'b1;
            end
            n.pos = pos + 32'd1;
        end

        st_next = n;
        push.num = fire ? num : 2'd0;
        push.r0 = ra;
        push.r1 = rb;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= PARSE_CLEAR;
        end else if (fire) begin
            st_reg <= st_next;
        end
    end

endmodule

// File: src/tchp_out_queue.sv
module tchp_out_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  tchp_pkg::push_t     push,
    input  logic                pop,
    output tchp_pkg::result_t   head,
    output logic                head_valid,
    output logic                room,
    output tchp_pkg::qstat_t    stat
);

    tchp_pkg::result_t                 entry_reg [tchp_pkg::QUEUE_DEPTH];
    logic [tchp_pkg::QPTR_W-1:0]       wr_reg;
    logic [tchp_pkg::QPTR_W-1:0]       rd_reg;
    logic [tchp_pkg::QCNT_W-1:0]       cnt_reg;
    logic [tchp_pkg::QPTR_W-1:0]       wr_plus;
    logic                              do_pop;

    assign wr_plus = wr_reg + tchp_pkg::QPTR_W'(1);
    assign do_pop = pop && (cnt_reg != '0);
    assign head = entry_reg[rd_reg];
    assign head_valid = (cnt_reg != '0);
    // Two free entries are needed, since one byte can cause two requests.
    assign room = (cnt_reg <= tchp_pkg::QCNT_W'(tchp_pkg::QUEUE_DEPTH - 2));
    assign stat.count = cnt_reg;

    always_ff @(posedge aclk) begin
        if (push.num != 2'd0) entry_reg[wr_reg] <= push.r0;
        if (push.num == 2'd2) entry_reg[wr_plus] <= push.r1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg <= wr_reg + tchp_pkg::QPTR_W'(push.num);
            if (do_pop) rd_reg <= rd_reg + tchp_pkg::QPTR_W'(1);
            cnt_reg <= cnt_reg + tchp_pkg::QCNT_W'(push.num) - tchp_pkg::QCNT_W'(do_pop);
        end
    end

endmodule

// File: src/texture_container_header_parser_core.sv
// Texture container header parser.
// The slave stream carries one container byte per request (s_tdata) with
// s_tuser marking the first byte of a new container. The parser checks the
// 12-byte identifier for version 1 or 2, gathers the header words and gives a
// header request, then level requests as level records are walked, and a done
// or not-recognized request at the container's last byte (file_length, which the
// user must set via APB address 0 while the block is idle, not enforced).
// One byte is taken every cycle while s_tready is high. Results are written
// into the result queue as the byte is accepted; one byte may cause two
// requests, which leave one per cycle while m_tready is high. A four-entry
// result queue sits between the two sides, so bytes keep flowing while
// results wait; s_tready drops only when fewer than two queue entries are
// free, which happens only when the receiver stalls. Reset empties the
// queue, restarts the parse and sets file_length to 1.
`include "texture_container_header_parser_core_defines.svh"

module texture_container_header_parser_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // byte_value
    input  logic                          s_tuser,   // start_of_file
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // version, format_code, width, height, depth, layers, faces,
    // count_or_index, level_offset, level_length, zero fill
    output logic [tchp_pkg::TDATA_W-1:0]  m_tdata,
    output logic [1:0]                    m_tuser,   // result_kind
    output logic                          m_tlast,   // last_of_run
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [1:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [31:0]        file_length_reg;
    logic               s_fire;
    tchp_pkg::push_t    push;
    tchp_pkg::result_t  head;
    tchp_pkg::qstat_t   qstat;
    logic               room;

    // Configuration register; writes complete in the access phase.
    assign pready = 1'b1;
    assign prdata = (paddr == tchp_pkg::REG_FILE_LENGTH) ? file_length_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_length_reg <= 32'd1;
        end else if (psel && penable && pwrite && paddr == tchp_pkg::REG_FILE_LENGTH) begin
            file_length_reg <= pwdata;
        end
    end

    assign s_tready = room;
    assign s_fire = s_tvalid && s_tready;

    tchp_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (s_fire),
        .byte_value    (s_tdata),
        .start_of_file (s_tuser),
        .file_length   (file_length_reg),
        .push          (push)
    );

    tchp_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop        (m_tready),
        .head       (head),
        .head_valid (m_tvalid),
        .room       (room),
        .stat       (qstat)
    );

    assign m_tuser = head.kind;
    assign m_tlast = head.last_of_run;
    assign m_tdata = {6'b0, head.level_length, head.level_offset, head.count_or_index,
                      head.faces, head.layers, head.depth, head.height, head.width,
                      head.format_code, head.version};

    // The queue never holds more than its depth.
    `TCHP_ASSERT_IMPL(a_queue_bound, 1'b1,
        qstat.count <= tchp_pkg::QCNT_W'(tchp_pkg::QUEUE_DEPTH))
    // A done or not-recognized request always closes its byte's run.
    `TCHP_ASSERT_IMPL(a_done_last,
        m_tvalid && (m_tuser == tchp_pkg::KIND_DONE || m_tuser == tchp_pkg::KIND_UNKNOWN),
        m_tlast)
    // A header request is only given for a recognized container.
    `TCHP_ASSERT_IMPL(a_header_version, m_tvalid && m_tuser == tchp_pkg::KIND_HEADER,
        m_tdata[1:0] != tchp_pkg::VER_NONE)
    // A full, stalled queue holds off the next byte.
    `TCHP_ASSERT_NEXT(a_full_stall,
        qstat.count == tchp_pkg::QCNT_W'(tchp_pkg::QUEUE_DEPTH) && !m_tready, !s_tready)

endmodule
